>>> rtl/nlp_pkg.sv
// Package for the numeric literal parser: token state type, position and
// status codes, and the character constants used by the step logic.
// No dependencies.
package nlp_pkg;

  localparam int unsigned ValueW  = 32;
  localparam int unsigned CharW   = 8;
  localparam int unsigned StatusW = 2;
  localparam int unsigned PosW    = 2;

  // token position codes
  localparam logic [PosW-1:0] PosStart = 2'd0;
  localparam logic [PosW-1:0] PosZero  = 2'd1;
  localparam logic [PosW-1:0] PosBody  = 2'd2;

  // result status codes
  localparam logic [StatusW-1:0] StOrdinal    = 2'd0;
  localparam logic [StatusW-1:0] StNotOrdinal = 2'd1;
  localparam logic [StatusW-1:0] StTooBig     = 2'd2;

  localparam logic [CharW-1:0] ChZero  = 8'h30;
  localparam logic [CharW-1:0] ChNine  = 8'h39;
  localparam logic [CharW-1:0] ChUpA   = 8'h41;
  localparam logic [CharW-1:0] ChUpZ   = 8'h5a;
  localparam logic [CharW-1:0] ChLowA  = 8'h61;
  localparam logic [CharW-1:0] ChLowF  = 8'h66;
  localparam logic [CharW-1:0] ChLowK  = 8'h6b;
  localparam logic [CharW-1:0] ChLowM  = 8'h6d;
  localparam logic [CharW-1:0] ChLowX  = 8'h78;
  localparam logic [CharW-1:0] CaseOff = 8'h20;

  localparam logic [ValueW-1:0] NarrowMax = 32'h0000_ffff;
  localparam int unsigned ShiftK = 10;
  localparam int unsigned ShiftM = 20;

  typedef struct packed {
    logic [ValueW-1:0] acc;
    logic              hex;
    logic              seen_digit;
    logic [PosW-1:0]   position;
    logic              failed;
  } state_t;

  typedef struct packed {
    logic               valid;
    logic [ValueW-1:0]  value;
    logic [StatusW-1:0] status;
  } result_t;

  localparam state_t StateClear = '{acc: '0, hex: 1'b0, seen_digit: 1'b0,
                                    position: PosStart, failed: 1'b0};

endpackage

>>> rtl/nlp_step.sv
// Next-state and result logic for one token character.
// Depends on nlp_pkg.
module nlp_step (
  input  nlp_pkg::state_t              state_i,
  input  logic [nlp_pkg::CharW-1:0]    char_i,
  input  logic                         last_i,
  input  logic                         empty_i,
  input  logic                         narrow_i,
  output nlp_pkg::state_t              state_o,
  output nlp_pkg::result_t             result_o
);
  import nlp_pkg::*;

  logic [CharW-1:0]  c;
  logic              take_body;
  logic              is_dec;
  logic              is_hex;
  logic [3:0]        digit;
  logic [ValueW-1:0] scaled;
  state_t            nxt;

  always_comb begin
    c = char_i;
    if (char_i >= ChUpA && char_i <= ChUpZ) begin
      c = char_i + CaseOff;
    end
  end

  assign is_dec = (c >= ChZero) && (c <= ChNine);
  assign is_hex = state_i.hex && (c >= ChLowA) && (c <= ChLowF);
  assign digit  = is_dec ? c[3:0] : 4'(c[3:0] + 4'd9);
  assign scaled = state_i.hex ? (state_i.acc << 4)
                              : ((state_i.acc << 3) + (state_i.acc << 1));

  always_comb begin
    nxt       = state_i;
    take_body = 1'b0;
    result_o  = '{valid: 1'b0, value: '0, status: StOrdinal};
    if (empty_i) begin
      nxt      = StateClear;
      result_o = '{valid: 1'b1, value: '0, status: StNotOrdinal};
    end else begin
      if (!state_i.failed) begin
        unique case (state_i.position)
          PosStart: begin
            if (c == ChZero && !last_i) nxt.position = PosZero;
            else                        take_body = 1'b1;
          end
          PosZero: begin
            if (c == ChLowX) begin
              nxt.hex      = 1'b1;
              nxt.position = PosBody;
            end else begin
              take_body = 1'b1;
            end
          end
          default: take_body = 1'b1;
        endcase
        if (take_body) begin
          nxt.position = PosBody;
          if (c == ChLowK || c == ChLowM) begin
            if (!last_i || !state_i.seen_digit) nxt.failed = 1'b1;
            else if (c == ChLowK) nxt.acc = state_i.acc << ShiftK;
            else                  nxt.acc = state_i.acc << ShiftM;
          end else if (is_dec || is_hex) begin
            nxt.acc        = scaled + {{(ValueW-4){1'b0}}, digit};
            nxt.seen_digit = 1'b1;
          end else begin
            nxt.failed = 1'b1;
          end
        end
      end
      if (last_i) begin
        result_o.valid = 1'b1;
        if (nxt.failed) begin
          result_o.status = StNotOrdinal;
        end else if (narrow_i && nxt.acc > NarrowMax) begin
          result_o.status = StTooBig;
        end else begin
          result_o.value = nxt.acc;
        end
        nxt = StateClear;
      end
    end
  end

  assign state_o = nxt;

endmodule

>>> rtl/numeric_literal_parser_top.sv
// Top level of the numeric literal parser: input register, token state,
// result register. Depends on nlp_pkg and nlp_step.
// Throughput: one item per cycle, except that an item yielding a result waits while
// the result register holds a result not yet taken; the token state update is a single
// shift-and-add step between the input register and the state register.
// Reset clears the token state and both valid flags; no clearing pass.
module numeric_literal_parser_top (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid_i,
  output logic                          s_axis_tready_o,
  input  logic [nlp_pkg::CharW-1:0]     s_axis_tdata_i,  // [7:0] char_code
  input  logic                          s_axis_tlast_i,  // last_char
  input  logic [1:0]                    s_axis_tuser_i,  // [0] empty_token, [1] narrow
  output logic                          m_axis_tvalid_o,
  input  logic                          m_axis_tready_i,
  output logic [nlp_pkg::ValueW-1:0]    m_axis_tdata_o,  // [31:0] value
  output logic [nlp_pkg::StatusW-1:0]   m_axis_tuser_o   // [1:0] status
);
  import nlp_pkg::*;

  logic             in_valid_q;
  logic [CharW-1:0] in_char_q;
  logic             in_last_q, in_empty_q, in_narrow_q;
  state_t           state_q, state_d;
  result_t          step_res;
  logic             out_valid_q;
  logic [ValueW-1:0]  out_value_q;
  logic [StatusW-1:0] out_status_q;
  logic             out_free, process;

  nlp_step u_step (
    .state_i  (state_q),
    .char_i   (in_char_q),
    .last_i   (in_last_q),
    .empty_i  (in_empty_q),
    .narrow_i (in_narrow_q),
    .state_o  (state_d),
    .result_o (step_res)
  );

  assign out_free        = !out_valid_q || m_axis_tready_i;
  assign process         = in_valid_q && (!step_res.valid || out_free);
  assign s_axis_tready_o = !in_valid_q || process;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready_o) begin
      in_valid_q <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready_o && s_axis_tvalid_i) begin
      in_char_q   <= s_axis_tdata_i;
      in_last_q   <= s_axis_tlast_i;
      in_empty_q  <= s_axis_tuser_i[0];
      in_narrow_q <= s_axis_tuser_i[1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StateClear;
    end else if (process) begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (process && step_res.valid) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (process && step_res.valid) begin
      out_value_q  <= step_res.value;
      out_status_q <= step_res.status;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_value_q;
  assign m_axis_tuser_o  = out_status_q;

  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> (m_axis_tuser_o == StOrdinal || m_axis_tuser_o == StNotOrdinal ||
                         m_axis_tuser_o == StTooBig))
    else $error("reserved status code on output");

  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tuser_o != StOrdinal) |-> m_axis_tdata_o == '0)
    else $error("nonzero value with failing status");

  a_clear_after_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (process && step_res.valid) |=> (state_q == StateClear))
    else $error("token state not cleared after result");

  a_zero_prefix: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q.position == PosZero) |-> (state_q.acc == '0 && !state_q.hex &&
                                       !state_q.seen_digit && !state_q.failed))
    else $error("dropped leading zero left nonclear state");

  a_hex_in_body: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q.hex |-> state_q.position == PosBody)
    else $error("hex mode outside token body");

endmodule
